// ----- rtl/wha_pkg.sv -----
// shared types and constants of the weighted histogram accumulator
// used by every rtl module of the block but wha_check; depends on nothing
`timescale 1ns / 1ps

package wha_pkg;

  // default window size in bins
  localparam int NUM_BINS_DEF = 1024;

  // field widths
  localparam int VALUE_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int OFFS_W   = 10;
  localparam int BWID_W   = 31;
  localparam int BIN_W    = 40;
  localparam int SUM_W    = 48;
  localparam int CMD_W    = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic key_en;
    logic anch_en;
    logic off_en;
    logic rd_en;
    logic upd_en;
    logic clr_step;
    logic out_load;
  } wha_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic clr_last;
    logic out_free;
  } wha_sts_t;

endpackage

// ----- rtl/wha_div.sv -----
// iterative restoring divider, one quotient bit per cycle, on magnitudes
// depends on wha_pkg
`timescale 1ns / 1ps

module wha_div
  import wha_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VALUE_W-1:0]  dividend,
  input  logic [BWID_W-1:0]   divisor,
  output logic                busy,
  output logic                neg,
  output logic [VALUE_W-1:0]  quo,
  output logic [BWID_W-1:0]   rem
);

  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [BWID_W-1:0]  rem_r, rem_nxt;
  logic [BWID_W-1:0]  dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [BWID_W:0]    trial;
  logic [BWID_W:0]    diff;

  // one restoring step: shift in next dividend bit, subtract when it fits
  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    trial   = {rem_r, quo_r[VALUE_W-1]};
    diff    = trial - {1'b0, dvs_r};
    if (start) begin
      neg_nxt = dividend[VALUE_W-1];
      quo_nxt = dividend[VALUE_W-1] ? (~dividend + VALUE_W'(1)) : dividend;
      rem_nxt = '0;
      dvs_nxt = (divisor == '0) ? BWID_W'(1) : divisor;
      cnt_nxt = CNT_W'(VALUE_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[BWID_W-1:0];
        quo_nxt = {quo_r[VALUE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BWID_W-1:0];
        quo_nxt = {quo_r[VALUE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = (cnt_r != '0);
  assign neg  = neg_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/wha_ctrl.sv -----
// controller state machine of the weighted histogram accumulator
// depends on wha_pkg; drives wha_datapath through wha_ctl_t
`timescale 1ns / 1ps

module wha_ctrl
  import wha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  input  wha_sts_t         sts,
  output wha_ctl_t         ctl
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_KEY  = 4'd2;
  localparam logic [3:0] ST_ANCH = 4'd3;
  localparam logic [3:0] ST_OFF  = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_UPD  = 4'd6;
  localparam logic [3:0] ST_CLR  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load = 1'b1;
          case (in_cmd)
            CMD_ADD:   state_nxt = ST_DIV;
            CMD_READ:  state_nxt = ST_RD;
            CMD_CLEAR: begin
              state_nxt = ST_CLR;
              emit_nxt  = 1'b1;
            end
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) state_nxt = ST_KEY;
      end
      ST_KEY: begin
        ctl.key_en = 1'b1;
        state_nxt  = ST_ANCH;
      end
      ST_ANCH: begin
        ctl.anch_en = 1'b1;
        state_nxt   = ST_OFF;
      end
      ST_OFF: begin
        ctl.off_en = 1'b1;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctl.upd_en = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = emit_r ? ST_FIN : ST_IDLE;
          emit_nxt  = 1'b0;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // reset starts with a sweep of the bin memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

// ----- rtl/wha_datapath.sv -----
// datapath of the weighted histogram accumulator: bin memory, window,
// totals and output register; depends on wha_pkg and wha_div
`timescale 1ns / 1ps

module wha_datapath
  import wha_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wha_ctl_t             ctl,
  output wha_sts_t             sts,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic [WEIGHT_W-1:0]  in_weight,
  input  logic [OFFS_W-1:0]    in_offset,
  input  logic                 cfg_valid,
  input  logic [BWID_W-1:0]    cfg_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [VALUE_W-1:0]   out_key,
  output logic [BIN_W-1:0]     out_weight,
  output logic [SUM_W-1:0]     out_total,
  output logic [VALUE_W-1:0]   out_low,
  output logic [VALUE_W-1:0]   out_high,
  output logic                 out_has_data,
  output logic                 out_dropped
);

  localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int OFF_W  = VALUE_W + 2;
  localparam logic signed [OFF_W-1:0] HALF_S = OFF_W'(NUM_BINS / 2);
  localparam logic signed [OFF_W-1:0] WS_MIN = -(OFF_W'(64'sd2147483648));
  localparam logic signed [OFF_W-1:0] WS_MAX = OFF_W'(64'sd2147483648 - NUM_BINS);
  localparam logic [BIN_W:0] BIN_MAX = {1'b0, {BIN_W{1'b1}}};
  localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

  // configuration and captured item
  logic [BWID_W-1:0]   bwid_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [WEIGHT_W-1:0] wt_r;
  logic [VALUE_W-1:0]  key_r;
  logic signed [OFF_W-1:0] off_r;

  // histogram state
  logic [VALUE_W-1:0]  ws_r;
  logic                anch_r;
  logic [SUM_W-1:0]    sum_r;
  logic [VALUE_W-1:0]  low_r;
  logic [VALUE_W-1:0]  high_r;
  logic                any_r;
  logic [ADDR_W-1:0]   clr_cnt_r;

  // result holding and output register
  logic [VALUE_W-1:0]  res_key_r;
  logic [BIN_W-1:0]    res_wt_r;
  logic                res_drop_r;
  logic                oval_r;

  // memory
  logic [BIN_W-1:0]    mem [NUM_BINS];
  logic [BIN_W-1:0]    rd_data_r;

  // divider
  logic                div_busy, div_neg;
  logic [VALUE_W-1:0]  div_quo;
  logic [BWID_W-1:0]   div_rem;

  wha_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.load && (in_cmd == CMD_ADD)),
    .dividend (in_value),
    .divisor  (bwid_r),
    .busy     (div_busy),
    .neg      (div_neg),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // floor key from magnitude quotient and remainder
  logic [VALUE_W-1:0] key_calc;
  always_comb begin
    if (!div_neg) key_calc = div_quo;
    else if (div_rem != '0) key_calc = ~div_quo;
    else key_calc = ~div_quo + VALUE_W'(1);
  end

  // anchor position clamped into the key range
  logic signed [OFF_W-1:0] key_s, ws_s, anch_s, anch_cl;
  always_comb begin
    key_s  = {{2{key_r[VALUE_W-1]}}, key_r};
    ws_s   = {{2{ws_r[VALUE_W-1]}}, ws_r};
    anch_s = key_s - HALF_S;
    if (anch_s < WS_MIN) anch_cl = WS_MIN;
    else if (anch_s > WS_MAX) anch_cl = WS_MAX;
    else anch_cl = anch_s;
  end

  // update arithmetic
  logic              inwin;
  logic [ADDR_W-1:0] addr;
  logic [BIN_W:0]    bsum;
  logic [BIN_W-1:0]  bsat;
  logic [SUM_W:0]    ssum;
  logic [SUM_W-1:0]  ssat;
  logic              lt_low, gt_high;
  always_comb begin
    inwin   = !off_r[OFF_W-1] && (off_r < OFF_W'(NUM_BINS));
    addr    = off_r[ADDR_W-1:0];
    bsum    = {1'b0, rd_data_r} + (BIN_W + 1)'(wt_r);
    bsat    = (bsum > BIN_MAX) ? BIN_MAX[BIN_W-1:0] : bsum[BIN_W-1:0];
    ssum    = {1'b0, sum_r} + (SUM_W + 1)'(wt_r);
    ssat    = (ssum > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : ssum[SUM_W-1:0];
    lt_low  = $signed(key_r) < $signed(low_r);
    gt_high = $signed(key_r) > $signed(high_r);
  end

  // memory write port: clearing sweep or bin update
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BIN_W-1:0]  wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = bsat;
    if (ctl.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (ctl.upd_en && (cmd_r == CMD_ADD) && inwin) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rd_data_r <= mem[addr];
  end

  // control state and histogram state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwid_r    <= BWID_W'(1);
      ws_r      <= '0;
      anch_r    <= 1'b0;
      sum_r     <= '0;
      low_r     <= '0;
      high_r    <= '0;
      any_r     <= 1'b0;
      clr_cnt_r <= '0;
      oval_r    <= 1'b0;
    end else begin
      if (cfg_valid) bwid_r <= cfg_data;
      if (ctl.load && (in_cmd == CMD_CLEAR)) begin
        ws_r   <= '0;
        anch_r <= 1'b0;
        sum_r  <= '0;
        low_r  <= '0;
        high_r <= '0;
        any_r  <= 1'b0;
      end
      if (ctl.anch_en && !anch_r) begin
        ws_r   <= anch_cl[VALUE_W-1:0];
        anch_r <= 1'b1;
      end
      if (ctl.upd_en && (cmd_r == CMD_ADD) && inwin && (wt_r != '0)) begin
        sum_r <= ssat;
        any_r <= 1'b1;
        if (!any_r || lt_low) low_r <= key_r;
        if (!any_r || gt_high) high_r <= key_r;
      end
      if (ctl.clr_step) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
      end
      if (ctl.out_load) oval_r <= 1'b1;
      else if (out_tready) oval_r <= 1'b0;
    end
  end

  // item capture and result building
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= in_cmd;
      wt_r       <= in_weight;
      off_r      <= OFF_W'(in_offset);
      res_key_r  <= '0;
      res_wt_r   <= '0;
      res_drop_r <= 1'b0;
    end
    if (ctl.key_en) key_r <= key_calc;
    if (ctl.off_en) off_r <= key_s - ws_s;
    if (ctl.upd_en) begin
      if (cmd_r == CMD_ADD) begin
        res_key_r  <= key_r;
        res_wt_r   <= inwin ? bsat : '0;
        res_drop_r <= !inwin;
      end else begin
        res_key_r <= ws_r + off_r[VALUE_W-1:0];
        res_wt_r  <= inwin ? rd_data_r : '0;
      end
    end
  end

  // output register, loaded with the totals as they stand
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_key      <= res_key_r;
      out_weight   <= res_wt_r;
      out_total    <= sum_r;
      out_low      <= low_r;
      out_high     <= high_r;
      out_has_data <= any_r;
      out_dropped  <= res_drop_r;
    end
  end

  assign out_tvalid   = oval_r;
  assign sts.div_busy = div_busy;
  assign sts.clr_last = (clr_cnt_r == ADDR_W'(NUM_BINS - 1));
  assign sts.out_free = !oval_r || out_tready;

endmodule

// ----- rtl/weighted_histogram_accumulator.sv -----
// Weighted histogram accumulator over a window of NUM_BINS bins. An add
// transaction bins its value with key = floor(value / bin_width) through a
// bit-serial divider and a read-modify-write of the bin memory. After reset
// the block sweeps the bin memory before it accepts the first item;
// configuration writes are taken at any time but are meant for idle periods.
// The divider and the bin memory accesses set the length of a transaction.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken.
// depends on wha_pkg, wha_ctrl, wha_datapath
`timescale 1ns / 1ps

module weighted_histogram_accumulator
  import wha_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // sample_value, sample_weight, bin_offset, zero pad
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // bin_key, bin_weight, total_weight, lowest_key,
                                   // highest_key, has_data, zero pad
  output logic         out_tuser,  // dropped
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data    // bin_width
);

  wha_ctl_t ctl;
  wha_sts_t sts;

  logic [VALUE_W-1:0] key, low, high;
  logic [BIN_W-1:0]   bweight;
  logic [SUM_W-1:0]   total;
  logic               has_data;

  wha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  wha_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_tuser),
    .in_value     (in_tdata[31:0]),
    .in_weight    (in_tdata[47:32]),
    .in_offset    (in_tdata[57:48]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_key      (key),
    .out_weight   (bweight),
    .out_total    (total),
    .out_low      (low),
    .out_high     (high),
    .out_has_data (has_data),
    .out_dropped  (out_tuser)
  );

  // result packing
  assign out_tdata = {7'd0, has_data, high, low, total, bweight, key};
  assign cfg_ready = 1'b1;

endmodule

// ----- rtl/wha_check.sv -----
// port-level checks of the weighted histogram accumulator, bound to the top
// depends on weighted_histogram_accumulator port layout
`timescale 1ns / 1ps

module wha_check (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic         out_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no data means both key limits read zero
  a_empty_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[184] |-> out_tdata[151:120] == 32'd0 &&
      out_tdata[183:152] == 32'd0)
    else $error("key limits set without data");

  // a dropped add reports zero bin weight
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[71:32] == 40'd0)
    else $error("dropped add with bin weight");

  // lowest key never above highest key
  a_limit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[184] |->
      $signed(out_tdata[151:120]) <= $signed(out_tdata[183:152]))
    else $error("lowest key above highest key");

endmodule

bind weighted_histogram_accumulator wha_check u_wha_check (.*);
